[rtl/xasf_pkg.sv]
package xasf_pkg;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_ADC = 3'd1,
        OP_SUB = 3'd2,
        OP_SBB = 3'd3,
        OP_INC = 3'd4,
        OP_DEC = 3'd5,
        OP_OR  = 3'd6
    } op_t;

    // flag bit positions in the status word
    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_PF = 2;
    localparam int unsigned FLAG_AF = 4;
    localparam int unsigned FLAG_ZF = 6;
    localparam int unsigned FLAG_SF = 7;
    localparam int unsigned FLAG_OF = 11;

    // flags written by each class of operation
    localparam logic [11:0] ARITH_FLAGS  = 12'h8D5;
    localparam logic [11:0] INCDEC_FLAGS = 12'h8D4;
    localparam logic [11:0] LOGIC_FLAGS  = 12'h8C5;

    typedef struct packed {
        logic [2:0]  operation;
        logic        word_size;
        logic [15:0] left_value;
        logic [15:0] right_value;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] result_value;
        logic [11:0] status_word;
    } rsp_word_t;

endpackage

[rtl/x86_alu_status_flags.sv]
// Byte/word ALU with its own flags register (CF, PF, AF, ZF, SF, OF at the usual
// bit positions of a 16-bit flags word). Each command word carries an operation
// (add, adc, sub, sbb, inc, dec, or), a size and two operands; each one gives
// exactly one response word with the truncated result and the full flags word
// after the operation. Adc and sbb take their carry from the stored CF; inc and
// dec keep CF; or clears CF and OF and keeps AF; code 7 is a no-op that returns
// zero and the unchanged flags. Throughput is one word per clock while the
// response side is not stalled: a command register feeds one short add/subtract
// plus flag logic into the response register, and the flags register is written
// in the same edge the response is loaded, so the next command sees the updated
// carry without a bubble. An accepted command waits in the command register and
// moves into the response register once that register is empty or being emptied.
// The response register lets a new command be taken while the previous response
// waits; cmd_stall is raised only when both the command and response registers
// are full and the response side is stalled.
module x86_alu_status_flags
    import xasf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,

    // command channel
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,

    // response channel
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    // command register
    logic      cmd_valid_reg;
    cmd_word_t cmd_word_reg;

    // response register
    logic      rsp_valid_reg;
    rsp_word_t rsp_word_reg;
    rsp_word_t rsp_word_next;

    // architectural flags
    logic [11:0] flag_bits_reg;
    logic [11:0] flag_bits_next;

    // handshake control
    logic rsp_load;   // response register takes a new word this edge
    logic cmd_load;   // command register may take a new word this edge

    assign rsp_load  = cmd_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_load  = !cmd_valid_reg || rsp_load;
    assign cmd_stall = !cmd_load;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    // operand shaping
    op_t         op;
    logic [15:0] a_val;
    logic [15:0] b_val;
    logic        c_in;
    logic [16:0] sum;
    logic [16:0] diff;
    logic [15:0] res;
    logic [15:0] res_masked;
    logic        carry_out;
    logic        sign_a;
    logic        sign_b;
    logic        sign_r;
    logic [11:0] flag_set;
    logic [11:0] flag_clear;

    always_comb
    begin
        op    = op_t'(cmd_word_reg.operation);
        a_val = cmd_word_reg.word_size ? cmd_word_reg.left_value
                                       : {8'h00, cmd_word_reg.left_value[7:0]};
        if (op == OP_INC || op == OP_DEC)
        begin
            b_val = 16'h0001;
        end
        else
        begin
            b_val = cmd_word_reg.word_size ? cmd_word_reg.right_value
                                           : {8'h00, cmd_word_reg.right_value[7:0]};
        end
        c_in = (op == OP_ADC || op == OP_SBB) ? flag_bits_reg[FLAG_CF] : 1'b0;

        sum  = {1'b0, a_val} + {1'b0, b_val} + {16'h0000, c_in};
        // borrow shows as bit 16 for both sizes since operands are zero extended
        diff = {1'b0, a_val} - {1'b0, b_val} - {16'h0000, c_in};

        res        = 16'h0000;
        carry_out  = 1'b0;
        flag_clear = 12'h000;
        flag_set   = 12'h000;

        unique case (op)
            OP_ADD, OP_ADC, OP_INC:
            begin
                res        = sum[15:0];
                carry_out  = cmd_word_reg.word_size ? sum[16] : sum[8];
                flag_clear = (op == OP_INC) ? INCDEC_FLAGS : ARITH_FLAGS;
            end
            OP_SUB, OP_SBB, OP_DEC:
            begin
                res        = diff[15:0];
                carry_out  = diff[16];
                flag_clear = (op == OP_DEC) ? INCDEC_FLAGS : ARITH_FLAGS;
            end
            OP_OR:
            begin
                res        = a_val | b_val;
                flag_clear = LOGIC_FLAGS;
            end
            default:
            begin
                // unused code: no-op, zero result, flags untouched
                res        = 16'h0000;
                flag_clear = 12'h000;
            end
        endcase

        res_masked = cmd_word_reg.word_size ? res : {8'h00, res[7:0]};

        sign_a = cmd_word_reg.word_size ? a_val[15]      : a_val[7];
        sign_b = cmd_word_reg.word_size ? b_val[15]      : b_val[7];
        sign_r = cmd_word_reg.word_size ? res_masked[15] : res_masked[7];

        // parity, zero and sign follow the result for every real operation
        flag_set[FLAG_PF] = ~^res_masked[7:0];
        flag_set[FLAG_ZF] = (res_masked == 16'h0000);
        flag_set[FLAG_SF] = sign_r;

        unique case (op)
            OP_ADD, OP_ADC, OP_INC:
            begin
                flag_set[FLAG_CF] = carry_out && (op != OP_INC);
                flag_set[FLAG_AF] = a_val[4] ^ b_val[4] ^ res_masked[4];
                flag_set[FLAG_OF] = (sign_a == sign_b) && (sign_a != sign_r);
            end
            OP_SUB, OP_SBB, OP_DEC:
            begin
                flag_set[FLAG_CF] = carry_out && (op != OP_DEC);
                flag_set[FLAG_AF] = a_val[4] ^ b_val[4] ^ res_masked[4];
                flag_set[FLAG_OF] = (sign_a != sign_b) && (sign_a != sign_r);
            end
            default:
            begin
                // or keeps only parity/zero/sign; no-op sets nothing
                if (op != OP_OR)
                begin
                    flag_set = 12'h000;
                end
            end
        endcase

        flag_bits_next = (flag_bits_reg & ~flag_clear) | flag_set;

        rsp_word_next.result_value = res_masked;
        rsp_word_next.status_word  = flag_bits_next;
    end

    // control and flags state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flag_bits_reg <= 12'h000;
        end
        else
        begin
            if (cmd_load)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                flag_bits_reg <= flag_bits_next;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_load && cmd_valid)
        begin
            cmd_word_reg <= cmd_word;
        end
        if (rsp_load)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

endmodule

[test/tb_top.sv]
module tb_top;
    import xasf_pkg::*;

    // code 7 is not an alu operation, the block treats it as a no-op
    localparam logic [2:0] OP_NOP = 3'd7;

    // receiver hold-off length and no-progress watchdog limit, in cycles
    localparam int HOLD_CYCLES = 60;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 363;

    // one row of the directed table, fixed_en marks a hand-typed expectation
    typedef struct {
        cmd_word_t cmd;
        logic      fixed_en;
        rsp_word_t fixed_rsp;
    } table_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_word_t cmd_word = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    rsp_word_t rsp_word;

    // hand-typed expectation that travels with the offered command word
    logic      fixed_en = 1'b0;
    rsp_word_t fixed_rsp = '0;

    // flags word as the model sees it, and responses still owed by the block
    logic [11:0] model_flags = '0;
    rsp_word_t   owed_rsps[$];
    rsp_word_t   predicted;
    rsp_word_t   oldest;
    table_row_t  stim_table[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_tickets = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stuck_cycles = 0;

    x86_alu_status_flags DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // alu step: returns the response word for one command given the current flags
    function automatic rsp_word_t alu_flags_next(input cmd_word_t c, input logic [11:0] flags);
        logic [16:0] msk;
        logic [16:0] sgn;
        logic [16:0] a;
        logic [16:0] b;
        logic [16:0] cin;
        logic [16:0] sum;
        logic [16:0] res;
        logic [11:0] f;
        logic [11:0] clr;
        logic        writes;
        rsp_word_t   r;
        msk    = c.word_size ? 17'h0FFFF : 17'h000FF;
        sgn    = c.word_size ? 17'h08000 : 17'h00080;
        a      = {1'b0, c.left_value} & msk;
        b      = {1'b0, c.right_value} & msk;
        cin    = {16'd0, flags[FLAG_CF]};
        res    = '0;
        f      = '0;
        clr    = '0;
        writes = 1'b1;
        case (c.operation)
            OP_ADD, OP_ADC, OP_INC:
            begin
                if (c.operation == OP_INC)
                    b = 17'd1;
                sum = a + b + ((c.operation == OP_ADC) ? cin : 17'd0);
                res = sum & msk;
                f[FLAG_CF] = (sum > msk);
                f[FLAG_AF] = ((a ^ b ^ res) & 17'h10) != 0;
                f[FLAG_OF] = ((~(a ^ b)) & (a ^ res) & sgn) != 0;
                clr = (c.operation == OP_INC) ? INCDEC_FLAGS : ARITH_FLAGS;
                // inc keeps the stored carry
                if (c.operation == OP_INC)
                    f[FLAG_CF] = 1'b0;
            end
            OP_SUB, OP_SBB, OP_DEC:
            begin
                if (c.operation == OP_DEC)
                    b = 17'd1;
                if (c.operation != OP_SBB)
                    cin = 17'd0;
                res = (a - b - cin) & msk;
                f[FLAG_CF] = (a < b + cin);
                f[FLAG_AF] = ((a ^ b ^ res) & 17'h10) != 0;
                f[FLAG_OF] = ((a ^ b) & (a ^ res) & sgn) != 0;
                clr = (c.operation == OP_DEC) ? INCDEC_FLAGS : ARITH_FLAGS;
                // dec keeps the stored carry
                if (c.operation == OP_DEC)
                    f[FLAG_CF] = 1'b0;
            end
            OP_OR:
            begin
                // cf and of cleared, af kept
                res = (a | b) & msk;
                clr = LOGIC_FLAGS;
            end
            default:
            begin
                // no-op: zero result, flags untouched
                writes = 1'b0;
            end
        endcase
        if (writes)
        begin
            f[FLAG_PF] = ~^res[7:0];
            f[FLAG_ZF] = (res == 17'd0);
            f[FLAG_SF] = (res & sgn) != 0;
        end
        r.result_value = res[15:0];
        r.status_word  = (flags & ~clr) | f;
        return r;
    endfunction

    // operand mix: full random, corner values and small numbers
    function automatic logic [15:0] pick_operand();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = 16'($urandom);
            2:
            begin
                case ($urandom_range(0, 6))
                    0: v = 16'h0000;
                    1: v = 16'hFFFF;
                    2: v = 16'h7FFF;
                    3: v = 16'h8000;
                    4: v = 16'h00FF;
                    5: v = 16'h0080;
                    default: v = 16'h007F;
                endcase
            end
            default: v = 16'($urandom_range(0, 15));
        endcase
        return v;
    endfunction

    task automatic table_row(input logic [2:0] op, input logic ws, input logic [15:0] a,
                             input logic [15:0] b, input logic fix,
                             input logic [15:0] res, input logic [11:0] st);
        table_row_t row;
        row.cmd.operation          = op;
        row.cmd.word_size          = ws;
        row.cmd.left_value         = a;
        row.cmd.right_value        = b;
        row.fixed_en               = fix;
        row.fixed_rsp.result_value = res;
        row.fixed_rsp.status_word  = st;
        stim_table.push_back(row);
    endtask

    // present one command word, with random idle cycles ahead of it, and hold
    // it until the block takes it
    task automatic offer_word(input cmd_word_t w, input logic fix, input rsp_word_t exp_rsp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_word  <= w;
        fixed_en  <= fix;
        fixed_rsp <= exp_rsp;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // sender goes quiet until every owed response word has come back
    task automatic drain_responses();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (owed_rsps.size() != 0)
            @(posedge clk);
    endtask

    // stimulus: reset, directed table, then four phases of random words
    initial
    begin
        cmd_word_t w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // typed rows: flags start at zero after reset and chain row to row
        table_row(OP_ADD, 1'b0, 16'h0000, 16'h0000, 1'b1, 16'h0000, 12'h044);
        table_row(OP_ADD, 1'b0, 16'h00FF, 16'h0001, 1'b1, 16'h0000, 12'h055);
        table_row(OP_NOP, 1'b0, 16'h1234, 16'h5678, 1'b1, 16'h0000, 12'h055);
        table_row(OP_ADC, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 12'h095);
        // byte size with junk in the high bytes
        table_row(OP_SBB, 1'b0, 16'hAB00, 16'h12FF, 1'b1, 16'h0000, 12'h055);
        table_row(OP_INC, 1'b1, 16'hFFFF, 16'h1234, 1'b1, 16'h0000, 12'h055);
        table_row(OP_DEC, 1'b0, 16'h0080, 16'hFFFF, 1'b1, 16'h007F, 12'h811);
        table_row(OP_OR,  1'b1, 16'h0000, 16'h0000, 1'b1, 16'h0000, 12'h054);
        table_row(OP_SUB, 1'b1, 16'h0000, 16'h0001, 1'b1, 16'hFFFF, 12'h095);
        table_row(OP_SUB, 1'b1, 16'h8000, 16'h0001, 1'b1, 16'h7FFF, 12'h814);
        // predictor-checked rows
        table_row(OP_ADD, 1'b0, 16'h007F, 16'h0001, 1'b0, 16'h0000, 12'h000);
        table_row(OP_ADD, 1'b1, 16'h8000, 16'h8000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_ADD, 1'b0, 16'h0008, 16'h0008, 1'b0, 16'h0000, 12'h000);
        table_row(OP_ADC, 1'b0, 16'h00FF, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_SUB, 1'b0, 16'h0000, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_SBB, 1'b1, 16'h0000, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_SBB, 1'b1, 16'h7FFF, 16'hFFFF, 1'b0, 16'h0000, 12'h000);
        table_row(OP_INC, 1'b0, 16'h00FF, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_INC, 1'b0, 16'h007F, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_DEC, 1'b1, 16'h0000, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_DEC, 1'b1, 16'h8000, 16'h0000, 1'b0, 16'h0000, 12'h000);
        table_row(OP_OR,  1'b0, 16'hFF0F, 16'h00F0, 1'b0, 16'h0000, 12'h000);
        table_row(OP_OR,  1'b1, 16'h8000, 16'h0001, 1'b0, 16'h0000, 12'h000);
        table_row(OP_NOP, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 12'h000);
        table_row(OP_ADD, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 12'h000);

        foreach (stim_table[i])
            offer_word(stim_table[i].cmd, stim_table[i].fixed_en, stim_table[i].fixed_rsp);
        drain_responses();

        // phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 65 : (phase == 3) ? 36 : 0;
            recv_stall_pct = (phase == 2) ? 65 : (phase == 3) ? 36 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold-off while words keep coming, block backs up
                if (phase == 0 && n == 30)
                    hold_tickets++;
                // sender pause mid-phase until the pipe is empty
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_responses();
                w.operation   = ($urandom_range(0, 19) == 0) ? OP_NOP
                                                             : 3'($urandom_range(0, 6));
                w.word_size   = 1'($urandom_range(0, 1));
                w.left_value  = pick_operand();
                w.right_value = pick_operand();
                offer_word(w, 1'b0, '0);
            end
            drain_responses();
        end

        // settle time for any stray response word
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stall, or a counted hold-off when the sender asks for one
    always @(posedge clk)
    begin
        if (hold_tickets != hold_seen)
        begin
            hold_seen = hold_tickets;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // predict on every accepted command word, check every accepted response word
    always @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            predicted   = alu_flags_next(cmd_word, model_flags);
            model_flags = predicted.status_word;
            if (fixed_en)
                owed_rsps.push_back(fixed_rsp);
            else
                owed_rsps.push_back(predicted);
        end
        if (rsp_valid && !rsp_stall)
        begin
            if (owed_rsps.size() == 0)
            begin
                $display("%0t unexpected response word: expected none actual %h", $time,
                         rsp_word);
                errors++;
            end
            else
            begin
                oldest = owed_rsps.pop_front();
                if (rsp_word.result_value !== oldest.result_value)
                begin
                    $display("%0t result_value mismatch: expected %h actual %h", $time,
                             oldest.result_value, rsp_word.result_value);
                    errors++;
                end
                if (rsp_word.status_word !== oldest.status_word)
                begin
                    $display("%0t status_word mismatch: expected %h actual %h", $time,
                             oldest.status_word, rsp_word.status_word);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
